// ===== src/i64af_pkg.sv =====
package i64af_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned FuncW  = 5;
    localparam int unsigned HalfW  = DataW / 2;
    localparam int unsigned ShamtW = $clog2(DataW);

    typedef enum logic [FuncW-1:0] {
        FN_ADD = 5'd0,  FN_SUB = 5'd1,  FN_MUL = 5'd2,  FN_DIV = 5'd3,
        FN_REM = 5'd4,  FN_XOR = 5'd5,  FN_AND = 5'd6,  FN_OR  = 5'd7,
        FN_SHL = 5'd8,  FN_SHR = 5'd9,  FN_EQ  = 5'd10, FN_NE  = 5'd11,
        FN_LT  = 5'd12, FN_LE  = 5'd13, FN_GT  = 5'd14, FN_GE  = 5'd15,
        FN_NOT = 5'd16, FN_NEG = 5'd17
    } t_func;

    // decode stage -> divider entry
    typedef struct packed {
        logic [FuncW-1:0] func;
        logic             ok;
        logic [DataW-1:0] simple;   // result of every op other than mul, div and rem
        logic [DataW-1:0] pp_ll;    // mul partial products
        logic [HalfW-1:0] pp_lh;
        logic [HalfW-1:0] pp_hl;
        logic [DataW-1:0] mag_a;
        logic [DataW-1:0] mag_b;
        logic             neg_q;
        logic             neg_r;
    } t_s1;

    // one divider stage
    typedef struct packed {
        logic [FuncW-1:0] func;
        logic             ok;
        logic [DataW-1:0] side;     // non-divide result riding along
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;      // dividend shifts out, quotient shifts in
        logic [DataW-1:0] den;
        logic             neg_q;
        logic             neg_r;
    } t_div;

    function automatic t_div div_step(input t_div d);
        t_div             o;
        logic [DataW:0]   t;
        logic [DataW:0]   diff;
        o    = d;
        t    = {d.rem, d.quo[DataW-1]};
        diff = t - {1'b0, d.den};
        if (!diff[DataW]) begin
            o.rem = diff[DataW-1:0];
            o.quo = {d.quo[DataW-2:0], 1'b1};
        end else begin
            o.rem = t[DataW-1:0];
            o.quo = {d.quo[DataW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== src/int64_alu_fold.sv =====
// 64-bit integer ALU, fully pipelined: one item accepted every cycle while the pipe is not
// stalled, results in order. Each item passes the stage-1 register, the signed divider (a
// chain of 64 restoring stages, one quotient bit per stage) and the output register; every
// other opcode rides along that chain so order is kept. The whole pipe stalls only when the
// output register holds an item the sink has not taken; tready follows that.
module int64_alu_fold
    import i64af_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,   // [4:0] func, [68:5] lhs, [132:69] rhs, rest zero
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata    // [63:0] result, [64] ok, rest zero
);

    localparam int unsigned NDiv = DataW;

    logic                 adv;
    logic [FuncW-1:0]     in_func;
    logic [DataW-1:0]     a, b;
    logic                 lt_ab, lt_ba;
    t_s1                  n_s1, r_s1;
    logic                 r_s1_vld;
    t_div                 div_in;
    t_div                 r_div [NDiv];
    logic [NDiv-1:0]      r_div_vld;
    logic [DataW-1:0]     r_res;
    logic                 r_ok, r_out_vld;
    logic [DataW-1:0]     n_res;
    logic                 n_ok;

    // global stall: everything moves when the output slot is free or drained
    assign adv        = !r_out_vld || i_m_tready;
    assign o_s_tready = adv;

    assign in_func = i_s_tdata[FuncW-1:0];
    assign a       = i_s_tdata[FuncW +: DataW];
    assign b       = i_s_tdata[FuncW+DataW +: DataW];

    // signed order via flipped sign bits
    assign lt_ab = {~a[DataW-1], a[DataW-2:0]} < {~b[DataW-1], b[DataW-2:0]};
    assign lt_ba = {~b[DataW-1], b[DataW-2:0]} < {~a[DataW-1], a[DataW-2:0]};

    // stage 1: decode, add/sub/neg, logic, shift and compare ops, mul partial products, magnitudes
    always_comb begin
        n_s1        = '0;
        n_s1.func   = in_func;
        n_s1.ok     = 1'b1;
        n_s1.pp_ll  = a[HalfW-1:0] * b[HalfW-1:0];
        n_s1.pp_lh  = HalfW'(a[HalfW-1:0] * b[DataW-1:HalfW]);
        n_s1.pp_hl  = HalfW'(a[DataW-1:HalfW] * b[HalfW-1:0]);
        n_s1.mag_a  = a[DataW-1] ? (~a + DataW'(1)) : a;
        n_s1.mag_b  = b[DataW-1] ? (~b + DataW'(1)) : b;
        n_s1.neg_q  = a[DataW-1] ^ b[DataW-1];
        n_s1.neg_r  = a[DataW-1];
        case (in_func)
            FN_ADD:  n_s1.simple = a + b;
            FN_SUB:  n_s1.simple = a - b;
            FN_XOR:  n_s1.simple = a ^ b;
            FN_AND:  n_s1.simple = a & b;
            FN_OR:   n_s1.simple = a | b;
            FN_SHL:  n_s1.simple = a << b[ShamtW-1:0];
            FN_SHR:  n_s1.simple = a >> b[ShamtW-1:0];
            FN_EQ:   n_s1.simple = DataW'(a == b);
            FN_NE:   n_s1.simple = DataW'(a != b);
            FN_LT:   n_s1.simple = DataW'(lt_ab);
            FN_LE:   n_s1.simple = DataW'(!lt_ba);
            FN_GT:   n_s1.simple = DataW'(lt_ba);
            FN_GE:   n_s1.simple = DataW'(!lt_ab);
            FN_NOT:  n_s1.simple = ~a;
            FN_NEG:  n_s1.simple = ~a + DataW'(1);
            FN_MUL:  n_s1.simple = '0;
            FN_DIV, FN_REM: begin
                n_s1.simple = '0;
                n_s1.ok     = (b != '0);
            end
            default: begin
                n_s1.simple = '0;
                n_s1.ok     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= n_s1;
        end
    end

    // divider entry: finish the low 64 bits of the product, load the magnitudes
    always_comb begin
        div_in       = '0;
        div_in.func  = r_s1.func;
        div_in.ok    = r_s1.ok;
        div_in.side  = (r_s1.func == FN_MUL)
                     ? r_s1.pp_ll + {r_s1.pp_lh + r_s1.pp_hl, {HalfW{1'b0}}}
                     : r_s1.simple;
        div_in.rem   = '0;
        div_in.quo   = r_s1.mag_a;
        div_in.den   = r_s1.mag_b;
        div_in.neg_q = r_s1.neg_q;
        div_in.neg_r = r_s1.neg_r;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NDiv; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_vld[k] <= 1'b0;
            end else if (adv) begin
                r_div_vld[k] <= (k == 0) ? r_s1_vld : r_div_vld[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_div[k] <= div_step((k == 0) ? div_in : r_div[(k == 0) ? 0 : k-1]);
            end
        end
    end

    // sign fixup, select, zero on failure
    always_comb begin
        t_div last;
        last = r_div[NDiv-1];
        n_ok = last.ok;
        case (last.func)
            FN_DIV:  n_res = last.neg_q ? (~last.quo + DataW'(1)) : last.quo;
            FN_REM:  n_res = last.neg_r ? (~last.rem + DataW'(1)) : last.rem;
            default: n_res = last.side;
        endcase
        if (!n_ok) begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_div_vld[NDiv-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
            r_ok  <= n_ok;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_ok, r_res};

endmodule

// ===== bench/tb_int64_alu_fold.sv =====
module tb_int64_alu_fold;
    import i64af_pkg::*;

    localparam int unsigned LATENCY   = 65;
    localparam int unsigned WDOG_MAX  = 20000;
    localparam int unsigned N_RANDOM  = 630;
    localparam logic [63:0] MIN_S64   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_S64   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } t_fold;

    typedef struct {
        logic [4:0]  func;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic        has_exp;   // typed-in expectation present
        t_fold       exp;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [135:0] i_s_tdata;    // [4:0] func, [68:5] lhs, [132:69] rhs, rest zero
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [71:0]  o_m_tdata;    // [63:0] result, [64] ok, rest zero

    int unsigned errors;
    int unsigned idle_cycles;
    bit          hold_sink;     // forced long receiver hold-off
    bit          src_done;
    t_fold       fold_expected[$];
    t_row        rows[$];

    int64_alu_fold dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // signed helpers: magnitudes and a sign-flipped compare, no reliance on tool signed division
    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic bit signed_less(input logic [63:0] a, input logic [63:0] b);
        return (a ^ MIN_S64) < (b ^ MIN_S64);
    endfunction

    function automatic t_fold fold_op(input logic [4:0] func, input logic [63:0] a,
                                      input logic [63:0] b);
        t_fold       r;
        logic [63:0] q;
        r.ok    = 1'b1;
        r.value = '0;
        case (func)
            FN_ADD: r.value = a + b;
            FN_SUB: r.value = a - b;
            FN_MUL: r.value = a * b;
            FN_DIV: begin
                if (b == 0) r.ok = 1'b0;
                else begin
                    q = magnitude(a) / magnitude(b);
                    r.value = (a[63] ^ b[63]) ? (~q + 64'd1) : q;
                end
            end
            FN_REM: begin
                if (b == 0) r.ok = 1'b0;
                else begin
                    q = magnitude(a) % magnitude(b);
                    r.value = a[63] ? (~q + 64'd1) : q;
                end
            end
            FN_XOR: r.value = a ^ b;
            FN_AND: r.value = a & b;
            FN_OR:  r.value = a | b;
            FN_SHL: r.value = a << b[5:0];
            FN_SHR: r.value = a >> b[5:0];
            FN_EQ:  r.value = {63'd0, a == b};
            FN_NE:  r.value = {63'd0, a != b};
            FN_LT:  r.value = {63'd0, signed_less(a, b)};
            FN_LE:  r.value = {63'd0, !signed_less(b, a)};
            FN_GT:  r.value = {63'd0, signed_less(b, a)};
            FN_GE:  r.value = {63'd0, !signed_less(a, b)};
            FN_NOT: r.value = ~a;
            FN_NEG: r.value = ~a + 64'd1;
            default: r.ok = 1'b0;
        endcase
        if (!r.ok) r.value = '0;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = MIN_S64;
            1: v = MAX_S64;
            2: v = ALL_ONES;
            3: v = '0;
            4: v = {{48{1'b0}}, 16'($urandom)};            // small positive
            5: v = -{{48{1'b0}}, 16'($urandom)};           // small negative
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic add_row(input logic [4:0] f, input logic [63:0] a, input logic [63:0] b,
                           input bit has_exp, input logic ok, input logic [63:0] v);
        t_row r;
        r.func    = f;
        r.lhs     = a;
        r.rhs     = b;
        r.has_exp = has_exp;
        r.exp     = '{ok: ok, value: v};
        rows.push_back(r);
    endtask

    // one item offered until taken, then sometimes a random gap
    task automatic send_item(input t_row r);
        t_fold pred;
        pred = fold_op(r.func, r.lhs, r.rhs);
        if (r.has_exp && pred !== r.exp) begin
            $display("%0t table row mismatch func=%0d exp=%h/%b got=%h/%b", $time, r.func,
                     r.exp.value, r.exp.ok, pred.value, pred.ok);
            errors++;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'd0, r.rhs, r.lhs, r.func};
        do @(posedge i_clk); while (!o_s_tready);
        fold_expected.push_back(r.has_exp ? r.exp : pred);
        if ($urandom_range(0, 3) != 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40))
                @(posedge i_clk);
        end
    endtask

    // sink: short random stalls, a few long ones, plus one forced hold-off
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_sink) i_m_tready <= 1'b0;
            else if ($urandom_range(0, 39) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
            else if ($urandom_range(0, 9) < 7) i_m_tready <= 1'b1;
            else i_m_tready <= 1'b0;
        end
    end

    // check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (fold_expected.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_m_tdata);
                errors++;
            end else begin
                t_fold e;
                e = fold_expected.pop_front();
                if (o_m_tdata[63:0] !== e.value) begin
                    $display("%0t result exp=%h act=%h", $time, e.value, o_m_tdata[63:0]);
                    errors++;
                end
                if (o_m_tdata[64] !== e.ok) begin
                    $display("%0t ok exp=%b act=%b", $time, e.ok, o_m_tdata[64]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_row r;
        errors      = 0;
        idle_cycles = 0;
        hold_sink   = 1'b0;
        src_done    = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;

        // directed table: extremes, every opcode, each special case
        add_row(FN_ADD, ALL_ONES, 64'd1,    1, 1'b1, 64'd0);
        add_row(FN_ADD, MAX_S64,  64'd1,    1, 1'b1, MIN_S64);
        add_row(FN_SUB, 64'd0,    64'd1,    1, 1'b1, ALL_ONES);
        add_row(FN_MUL, ALL_ONES, ALL_ONES, 1, 1'b1, 64'd1);
        add_row(FN_DIV, 64'd5,    64'd0,    1, 1'b0, 64'd0);       // divide by zero
        add_row(FN_REM, ALL_ONES, 64'd0,    1, 1'b0, 64'd0);
        add_row(FN_DIV, MIN_S64,  ALL_ONES, 1, 1'b1, MIN_S64);     // min over minus one
        add_row(FN_REM, MIN_S64,  ALL_ONES, 1, 1'b1, 64'd0);
        add_row(FN_DIV, -64'd7,   64'd2,    1, 1'b1, -64'd3);      // truncates toward zero
        add_row(FN_REM, -64'd7,   64'd2,    1, 1'b1, ALL_ONES);    // sign of lhs
        add_row(FN_REM, 64'd7,    -64'd2,   1, 1'b1, 64'd1);
        add_row(FN_XOR, ALL_ONES, 64'h5555_5555_5555_5555, 0, 0, 0);
        add_row(FN_AND, ALL_ONES, 64'h0123_4567_89AB_CDEF, 0, 0, 0);
        add_row(FN_OR,  64'd0,    ALL_ONES, 1, 1'b1, ALL_ONES);
        add_row(FN_SHL, 64'd1,    64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1, MIN_S64); // high bits dropped
        add_row(FN_SHR, MIN_S64,  64'd63,   1, 1'b1, 64'd1);
        add_row(FN_EQ,  ALL_ONES, ALL_ONES, 1, 1'b1, 64'd1);
        add_row(FN_NE,  ALL_ONES, ALL_ONES, 1, 1'b1, 64'd0);
        add_row(FN_LT,  MIN_S64,  MAX_S64,  1, 1'b1, 64'd1);
        add_row(FN_LE,  MAX_S64,  MAX_S64,  1, 1'b1, 64'd1);
        add_row(FN_GT,  ALL_ONES, 64'd0,    1, 1'b1, 64'd0);
        add_row(FN_GE,  64'd0,    ALL_ONES, 1, 1'b1, 64'd1);
        add_row(FN_NOT, 64'd0,    ALL_ONES, 1, 1'b1, ALL_ONES);   // rhs ignored
        add_row(FN_NEG, MIN_S64,  64'd3,    1, 1'b1, MIN_S64);
        add_row(5'd18,  ALL_ONES, ALL_ONES, 1, 1'b0, 64'd0);      // unknown opcodes
        add_row(5'd31,  64'd1,    64'd1,    1, 1'b0, 64'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_item(rows[k]);

        // sender pause until all results are back
        i_s_tvalid <= 1'b0;
        wait (fold_expected.size() == 0);
        @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) begin
                // long receiver hold-off while items keep coming: the whole pipe and the input stall
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (LATENCY * 3) @(posedge i_clk);
                        hold_sink = 1'b0;
                    end
                join_none
            end
            r.func    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(18, 31))
                                                    : 5'($urandom_range(0, 17));
            r.lhs     = rand64();
            r.rhs     = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
            r.has_exp = 1'b0;
            r.exp     = '0;
            send_item(r);
        end
        i_s_tvalid <= 1'b0;

        wait (fold_expected.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
